@@ rtl/core/du32c_pkg.sv @@
// Shared types and constants for the double/unorm32 converter.
package du32c_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic KIND_TO_UNORM  = 1'b0;
  localparam logic KIND_TO_DOUBLE = 1'b1;

  localparam logic [31:0] UNORM_MAX = 32'hFFFF_FFFF;
  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;

  // Classified item as it waits between the front and the back.
  // For the double direction zero/sat force 0 or full scale; for the
  // integer direction zero means u == 0 and sat means u == full scale.
  typedef struct packed {
    logic        kind;
    logic        zero;
    logic        sat;
    logic [52:0] mant;
    logic [10:0] bexp;
    logic [31:0] u;
  } du32c_item_t;

endpackage

@@ rtl/core/du32c_front.sv @@
// Front end: classify incoming operands and hold them in a short queue.
module du32c_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [63:0]           in_operand,
  output logic                  q_valid,
  input  logic                  q_pop,
  output du32c_pkg::du32c_item_t q_item
);
  import du32c_pkg::*;

  du32c_item_t    mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  du32c_item_t    cls;
  logic           push;
  logic           pop;
  logic           sgn;
  logic [10:0]    ef;
  logic [51:0]    fr;
  logic           nan;

  always_comb begin
    sgn = in_operand[63];
    ef  = in_operand[62:52];
    fr  = in_operand[51:0];
    nan = (ef == 11'h7FF) && (fr != 52'd0);
    cls.kind = in_kind;
    cls.mant = {1'b1, fr};
    cls.bexp = ef;
    cls.u    = in_operand[31:0];
    if (in_kind == KIND_TO_UNORM) begin
      cls.zero = nan || sgn || (ef == 11'd0);
      cls.sat  = !(nan || sgn || (ef == 11'd0)) && (in_operand[62:0] > ONE_BITS[62:0]);
    end else begin
      cls.zero = (in_operand[31:0] == 32'd0);
      cls.sat  = (in_operand[31:0] == UNORM_MAX);
    end
  end

  assign in_ready = (count_r != (QAW+1)'(QDEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == (QAW+1)'(QDEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

endmodule

@@ rtl/core/du32c_back.sv @@
// Back end: three-step conversion pipeline with an output register.
module du32c_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  du32c_pkg::du32c_item_t q_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_result
);
  import du32c_pkg::*;

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  logic en;

  // step 1
  logic        s1_valid_r;
  logic        s1_kind_r, s1_zero_r, s1_sat_r;
  logic [84:0] s1_prod_r;
  logic [10:0] s1_bexp_r;
  logic [4:0]  s1_lz_r;
  logic [31:0] s1_u_r;

  // step 2
  logic        s2_valid_r;
  logic        s2_kind_r, s2_zero_r, s2_sat_r;
  logic [53:0] s2_q_r;
  logic [10:0] s2_k_r;
  logic [63:0] s2_dres_r;

  logic        out_valid_r;
  logic [63:0] out_result_r;

  logic [53:0] q_nxt;
  logic [10:0] k_nxt;
  logic [63:0] dres_nxt;
  logic [95:0] win;
  logic [10:0] dexp;
  logic        rb_hi, st_hi, rb_lo, st_lo, up;

  logic [117:0] shx;
  logic [53:0]  ipart;
  logic         irb, ist, iup;
  logic [54:0]  isum;
  logic [63:0]  result_nxt;

  assign en         = !out_valid_r || out_ready;
  assign q_pop      = en;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Step 1: exact product m*(2^32-1), leading zeros of u.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= q_item.kind;
      s1_zero_r <= q_item.zero;
      s1_sat_r  <= q_item.sat;
      s1_prod_r <= {q_item.mant, 32'd0} - {32'd0, q_item.mant};
      s1_bexp_r <= q_item.bexp;
      s1_lz_r   <= lzc32(q_item.u);
      s1_u_r    <= q_item.u;
    end
  end

  // Step 2: round product to 53 bits; build the double quotient.
  always_comb begin
    rb_hi = s1_prod_r[31];
    st_hi = |s1_prod_r[30:0];
    rb_lo = s1_prod_r[30];
    st_lo = |s1_prod_r[29:0];
    if (s1_prod_r[84]) begin
      up    = rb_hi && (st_hi || s1_prod_r[32]);
      q_nxt = {1'b0, s1_prod_r[84:32]} + {53'd0, up};
      k_nxt = 11'd1075 - s1_bexp_r - 11'd32;
    end else begin
      up    = rb_lo && (st_lo || s1_prod_r[31]);
      q_nxt = {1'b0, s1_prod_r[83:31]} + {53'd0, up};
      k_nxt = 11'd1075 - s1_bexp_r - 11'd31;
    end
    // u/(2^32-1) repeats u in every 32-bit group; the tail never stops,
    // so a set round bit always rounds up.
    win      = {s1_u_r, s1_u_r, s1_u_r} << s1_lz_r;
    dexp     = 11'd1022 - {6'd0, s1_lz_r};
    dres_nxt = {1'b0, dexp, win[94:43]} + {63'd0, win[42]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_kind_r;
      s2_zero_r <= s1_zero_r;
      s2_sat_r  <= s1_sat_r;
      s2_q_r    <= q_nxt;
      s2_k_r    <= k_nxt;
      s2_dres_r <= dres_nxt;
    end
  end

  // Step 3: scale to an integer, ties to even, and pick the result.
  // Saturated operands can carry a wrapped shift count, so test them first.
  always_comb begin
    shx   = {s2_q_r, 64'd0} >> s2_k_r[5:0];
    ipart = shx[117:64];
    irb   = shx[63];
    ist   = |shx[62:0];
    iup   = irb && (ist || ipart[0]);
    isum  = {1'b0, ipart} + {54'd0, iup};
    if (s2_kind_r == KIND_TO_UNORM) begin
      if (s2_zero_r) begin
        result_nxt = 64'd0;
      end else if (s2_sat_r) begin
        result_nxt = {32'd0, UNORM_MAX};
      end else if (s2_k_r > 11'd63) begin
        result_nxt = 64'd0;
      end else begin
        result_nxt = {32'd0, isum[31:0]};
      end
    end else begin
      if (s2_zero_r) begin
        result_nxt = 64'd0;
      end else if (s2_sat_r) begin
        result_nxt = ONE_BITS;
      end else begin
        result_nxt = s2_dres_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= result_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (s2_valid_r == $past(s2_valid_r)))
    else $error("pipeline advanced under stall");
  a_unorm_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_valid_r && s2_kind_r == KIND_TO_UNORM) |=> (out_result_r[63:32] == 32'd0))
    else $error("unorm result has upper bits set");
  a_double_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (en && s2_valid_r && s2_kind_r == KIND_TO_DOUBLE) |=> (out_result_r <= ONE_BITS))
    else $error("quotient exceeds one");

endmodule

@@ rtl/core/double_unorm32_converter_core.sv @@
// Top level of the binary64 <-> unorm32 pixel component converter.
//
// Input channel (in_*): one transfer per component. in_tuser selects the
// direction (0: binary64 bits to unorm32, 1: unorm32 to binary64 bits) and
// in_tdata carries the operand. Output channel (out_*): one transfer per
// input transfer, in order, result in out_tdata.
// Throughput: one transfer per cycle when the receiver keeps out_tready
// high. The transfer edge writes the queue; the pipeline then registers
// the product, the 53-bit rounding and the integer rounding, the last
// into the output register, which drives out_tdata.
// The four-entry queue between the classifier and the arithmetic pipeline
// decouples the sides: in_tready depends only on queue fill, not on
// out_tready, so the input keeps flowing while a result waits.
// When the receiver stalls, the pipeline and output register hold; the
// queue then fills and in_tready drops after at most four more transfers.
// Reset (rst_n low, synchronous) empties the queue and clears all valid
// flags; the data registers are not reset, and there is no configuration.
// Special values: NaN, negatives and -0 give 0; values above 1.0 give
// full scale; u = 0 gives +0.0 and u = full scale gives 1.0.
module double_unorm32_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] operand
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] result
);
  import du32c_pkg::*;

  du32c_item_t q_item;
  logic        q_valid;
  logic        q_pop;

  // Classify and enqueue each transfer.
  du32c_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_operand (in_tdata),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  // Convert and present results; advance only when the output can move.
  du32c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_tdata)
  );

endmodule
